### rtl/indexed_deque_macros.svh
// Assertion helpers used by the deque sequencer (idq_ctrl).
`ifndef INDEXED_DEQUE_MACROS_SVH
`define INDEXED_DEQUE_MACROS_SVH
`ifndef SYNTH
// Check on every rising edge outside reset.
`define IDQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("indexed_deque check failed");
// Check on every rising edge, reset included.
`define IDQ_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("indexed_deque reset check failed");
`else
`define IDQ_ASSERT(lbl, clk, rstn, prop)
`define IDQ_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### rtl/idq_pkg.sv
`default_nettype none
package idq_pkg;

  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_REMOVE     = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_FULL        = 2'd1,
    STAT_RANGE       = 2'd2,
    STAT_POP_REFUSED = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REMOVE = 1'b1
  } state_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic shift_r;
    logic shift_l;
    logic wr_en;
  } cell_cmd_t;

  // Result control from the sequencer to the output register.
  typedef struct packed {
    logic    load;
    logic    rd_en;
    status_e status;
  } res_t;

endpackage
`default_nettype wire

### rtl/indexed_deque.sv
// indexed_deque: a bounded double-ended queue of words that never runs empty.
// Input channel: in_valid_i / in_stall_o with operation_i, value_i, position_i.
// An item is taken at a rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with read_data_o, count_o, status_o;
// exactly one result per item, in order.
// Push, pop, read and write finish in the cycle of acceptance; the result shows
// in the output register in the following cycle, and a new item can be taken every
// cycle while the receiver keeps up.
// Remove-matching walks the cell row through a single comparator at the front
// cell, one entry per cycle after acceptance: with n entries (1 to DEPTH) its
// result shows once all n have been walked, and the next item is taken no
// sooner than that. No item is taken during that walk.
// While out_stall_i holds a waiting result, the result is held and in_stall_o
// is raised, so at most one result is ever pending.
// Reset leaves one zero entry (count 1) and an empty output register.
`default_nettype none
module indexed_deque #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [idq_pkg::OP_W-1:0]    operation_i,
  input  wire logic [idq_pkg::VAL_W-1:0]   value_i,
  input  wire logic [idq_pkg::POS_W-1:0]   position_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [idq_pkg::VAL_W-1:0]   read_data_o,
  output logic      [idq_pkg::CNT_W-1:0]   count_o,
  output logic      [idq_pkg::ST_W-1:0]    status_o
);

  localparam int EW = (WIDTH < idq_pkg::VAL_W) ? WIDTH : idq_pkg::VAL_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  // Only the first entries can be addressed by the position field.
  localparam int RN = (DEPTH < (1 << idq_pkg::POS_W)) ? DEPTH : (1 << idq_pkg::POS_W);

  idq_pkg::cell_cmd_t cmd;
  idq_pkg::res_t      res;
  logic [AW-1:0]      wr_idx;
  logic [EW-1:0]      wr_data;
  logic [CW-1:0]      res_occ;
  logic [EW-1:0]      value_m;
  logic [EW-1:0]      cell_data [DEPTH];
  logic [EW-1:0]      rd_data;
  logic               out_busy;

  logic                         out_valid_q;
  logic [idq_pkg::VAL_W-1:0]    read_data_q;
  logic [idq_pkg::CNT_W-1:0]    count_q;
  logic [idq_pkg::ST_W-1:0]     status_q;

  assign value_m  = EW'(value_i);
  assign out_busy = out_valid_q && out_stall_i;

  idq_ctrl #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_busy_i  (out_busy),
    .operation_i (operation_i),
    .value_i     (value_m),
    .position_i  (position_i),
    .head_i      (cell_data[0]),
    .cmd_o       (cmd),
    .wr_idx_o    (wr_idx),
    .wr_data_o   (wr_data),
    .res_o       (res),
    .res_occ_o   (res_occ)
  );

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [EW-1:0] left_n;
    logic [EW-1:0] right_n;
    if (g == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid_l
      assign left_n = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_mid_r
      assign right_n = cell_data[g+1];
    end
    idq_cell #(
      .W     (EW),
      .AW    (AW),
      .INDEX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .wr_idx_i  (wr_idx),
      .wr_data_i (wr_data),
      .left_i    (left_n),
      .right_i   (right_n),
      .data_o    (cell_data[g])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < RN; i++) begin
      if (position_i == idq_pkg::POS_W'(i)) begin
        rd_data = cell_data[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      read_data_q <= res.rd_en ? idq_pkg::VAL_W'(rd_data) : '0;
      count_q     <= idq_pkg::CNT_W'(res_occ);
      status_q    <= res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

endmodule
`default_nettype wire

### rtl/idq_cell.sv
`default_nettype none
module idq_cell #(
  parameter int W     = 32,
  parameter int AW    = 4,
  parameter int INDEX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire idq_pkg::cell_cmd_t cmd_i,
  input  wire logic [AW-1:0]     wr_idx_i,
  input  wire logic [W-1:0]      wr_data_i,
  input  wire logic [W-1:0]      left_i,
  input  wire logic [W-1:0]      right_i,
  output logic      [W-1:0]      data_o
);

  logic [W-1:0] data_q, data_d;
  logic         hit;

  assign hit = cmd_i.wr_en && (wr_idx_i == AW'(INDEX));

  // A direct write wins over the shift.
  always_comb begin
    data_d = data_q;
    if (hit) begin
      data_d = wr_data_i;
    end else if (cmd_i.shift_r) begin
      data_d = left_i;
    end else if (cmd_i.shift_l) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

### rtl/idq_ctrl.sv
`default_nettype none
`include "indexed_deque_macros.svh"
module idq_ctrl #(
  parameter int DEPTH = 16,
  parameter int EW    = 32,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       out_busy_i,
  input  wire logic [idq_pkg::OP_W-1:0]   operation_i,
  input  wire logic [EW-1:0]              value_i,
  input  wire logic [idq_pkg::POS_W-1:0]  position_i,
  input  wire logic [EW-1:0]              head_i,
  output idq_pkg::cell_cmd_t              cmd_o,
  output logic      [AW-1:0]              wr_idx_o,
  output logic      [EW-1:0]              wr_data_o,
  output idq_pkg::res_t                   res_o,
  output logic      [CW-1:0]              res_occ_o
);

  localparam int CMPW = (CW > idq_pkg::POS_W) ? CW : idq_pkg::POS_W;

  idq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   occ_q, occ_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   k_q, k_d;
  logic [EW-1:0]   val_q, val_d;
  logic            accept;
  logic            in_range;
  logic            full;
  logic            single;
  logic            keep_wr;

  assign in_stall_o = (state_q == idq_pkg::S_REMOVE) || out_busy_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = CMPW'(position_i) < CMPW'(occ_q);
  assign full       = occ_q == CW'(DEPTH);
  assign single     = occ_q == CW'(1);
  // Keep the head, or keep the match itself when it is the last and nothing survived.
  assign keep_wr    = (head_i != val_q) || ((n_q == CW'(1)) && (k_q == '0));

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    n_d       = n_q;
    k_d       = k_q;
    val_d     = val_q;
    cmd_o     = '0;
    wr_idx_o  = '0;
    wr_data_o = '0;
    res_o     = '0;
    unique case (state_q)
      idq_pkg::S_IDLE: begin
        if (accept) begin
          res_o.load   = 1'b1;
          res_o.status = idq_pkg::STAT_OK;
          unique case (idq_pkg::op_e'(operation_i))
            idq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_o.status = idq_pkg::STAT_FULL;
              end else begin
                cmd_o.shift_r = 1'b1;
                cmd_o.wr_en   = 1'b1;
                wr_idx_o      = '0;
                wr_data_o     = value_i;
                occ_d         = occ_q + 1'b1;
              end
            end
            idq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_o.status = idq_pkg::STAT_FULL;
              end else begin
                cmd_o.wr_en = 1'b1;
                wr_idx_o    = AW'(occ_q);
                wr_data_o   = value_i;
                occ_d       = occ_q + 1'b1;
              end
            end
            idq_pkg::OP_POP_FRONT: begin
              if (single) begin
                res_o.status = idq_pkg::STAT_POP_REFUSED;
              end else begin
                cmd_o.shift_l = 1'b1;
                occ_d         = occ_q - 1'b1;
              end
            end
            idq_pkg::OP_POP_BACK: begin
              if (single) begin
                res_o.status = idq_pkg::STAT_POP_REFUSED;
              end else begin
                cmd_o.wr_en = 1'b1;
                wr_idx_o    = AW'(occ_q - 1'b1);
                occ_d       = occ_q - 1'b1;
              end
            end
            idq_pkg::OP_READ: begin
              if (in_range) begin
                res_o.rd_en = 1'b1;
              end else begin
                res_o.status = idq_pkg::STAT_RANGE;
              end
            end
            idq_pkg::OP_WRITE: begin
              if (in_range) begin
                cmd_o.wr_en = 1'b1;
                wr_idx_o    = AW'(position_i);
                wr_data_o   = value_i;
              end else begin
                res_o.status = idq_pkg::STAT_RANGE;
              end
            end
            idq_pkg::OP_REMOVE: begin
              res_o.load = 1'b0;
              val_d      = value_i;
              n_d        = occ_q;
              k_d        = '0;
              state_d    = idq_pkg::S_REMOVE;
            end
            default: begin
            end
          endcase
        end
      end
      idq_pkg::S_REMOVE: begin
        // Take the head off the front; a survivor goes behind the unscanned part.
        cmd_o.shift_l = 1'b1;
        if (keep_wr) begin
          cmd_o.wr_en = 1'b1;
          wr_idx_o    = AW'(n_q + k_q - 1'b1);
          wr_data_o   = head_i;
          k_d         = k_q + 1'b1;
        end
        n_d = n_q - 1'b1;
        if (n_q == CW'(1)) begin
          occ_d        = k_d;
          res_o.load   = 1'b1;
          res_o.status = idq_pkg::STAT_OK;
          state_d      = idq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = idq_pkg::S_IDLE;
      end
    endcase
  end

  assign res_occ_o = occ_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idq_pkg::S_IDLE;
      occ_q   <= CW'(1);
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      n_q     <= n_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  `IDQ_ASSERT(a_occ_bounds, clk_i, rst_ni, (occ_q != '0) && (occ_q <= CW'(DEPTH)))
  `IDQ_ASSERT(a_load_free, clk_i, rst_ni, res_o.load |-> !out_busy_i)
  `IDQ_ASSERT(a_scan_live, clk_i, rst_ni, (state_q == idq_pkg::S_REMOVE) |-> (n_q != '0))
  `IDQ_ASSERT_RST(a_reset_state, clk_i, !rst_ni |=> (state_q == idq_pkg::S_IDLE && occ_q == CW'(1)))

endmodule
`default_nettype wire

### bench/indexed_deque_tb.sv
`timescale 1ns / 100ps
module indexed_deque_tb;

  localparam int DEPTH = 16;
  localparam int WIDTH = 32;
  localparam logic [idq_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 150;
  localparam int TAIL_CYCLES = DEPTH + 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 820;

  typedef struct packed {
    logic [idq_pkg::VAL_W-1:0] read_data;
    logic [idq_pkg::CNT_W-1:0] count;
    idq_pkg::status_e          status;
  } deque_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [idq_pkg::OP_W-1:0]  operation_i = '0;
  logic [idq_pkg::VAL_W-1:0] value_i = '0;
  logic [idq_pkg::POS_W-1:0] position_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [idq_pkg::VAL_W-1:0] read_data_o;
  logic [idq_pkg::CNT_W-1:0] count_o;
  logic [idq_pkg::ST_W-1:0]  status_o;

  // Shadow copy of the deque contents
  logic [WIDTH-1:0] deque_words [DEPTH];
  int               deque_fill;
  deque_result_t    pending_results[$];

  logic [idq_pkg::VAL_W-1:0] value_pool [4];
  int               errors = 0;
  int               results_checked = 0;
  int               items_sent = 0;
  int               op_seen [8];
  int               status_seen [4];
  int               idle_cycles = 0;
  bit               hold_request = 1'b0;

  indexed_deque #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o),
    .count_o     (count_o),
    .status_o    (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one request to the shadow deque and return the result it gives.
  function automatic deque_result_t deque_apply(input logic [idq_pkg::OP_W-1:0] op,
                                                input logic [idq_pkg::VAL_W-1:0] val,
                                                input logic [idq_pkg::POS_W-1:0] pos);
    deque_result_t res;
    int i;
    int kept;
    res = '{read_data: '0, count: '0, status: idq_pkg::STAT_OK};
    case (op)
      idq_pkg::OP_PUSH_FRONT: begin
        if (deque_fill >= DEPTH) begin
          res.status = idq_pkg::STAT_FULL;
        end else begin
          for (i = deque_fill; i > 0; i--) deque_words[i] = deque_words[i-1];
          deque_words[0] = val;
          deque_fill++;
        end
      end
      idq_pkg::OP_PUSH_BACK: begin
        if (deque_fill >= DEPTH) begin
          res.status = idq_pkg::STAT_FULL;
        end else begin
          deque_words[deque_fill] = val;
          deque_fill++;
        end
      end
      idq_pkg::OP_POP_FRONT: begin
        if (deque_fill <= 1) begin
          res.status = idq_pkg::STAT_POP_REFUSED;
        end else begin
          for (i = 0; i + 1 < deque_fill; i++) deque_words[i] = deque_words[i+1];
          deque_fill--;
          deque_words[deque_fill] = '0;
        end
      end
      idq_pkg::OP_POP_BACK: begin
        if (deque_fill <= 1) begin
          res.status = idq_pkg::STAT_POP_REFUSED;
        end else begin
          deque_fill--;
          deque_words[deque_fill] = '0;
        end
      end
      idq_pkg::OP_READ: begin
        if (pos >= deque_fill) res.status = idq_pkg::STAT_RANGE;
        else res.read_data = deque_words[pos];
      end
      idq_pkg::OP_WRITE: begin
        if (pos >= deque_fill) res.status = idq_pkg::STAT_RANGE;
        else deque_words[pos] = val;
      end
      idq_pkg::OP_REMOVE: begin
        kept = 0;
        for (i = 0; i < deque_fill; i++) begin
          if (deque_words[i] != val) begin
            deque_words[kept] = deque_words[i];
            kept++;
          end
        end
        // keep one entry when everything matched
        if (kept == 0) begin
          deque_words[0] = val;
          kept = 1;
        end
        for (i = kept; i < DEPTH; i++) deque_words[i] = '0;
        deque_fill = kept;
      end
      default: ;
    endcase
    res.count = deque_fill[idq_pkg::CNT_W-1:0];
    return res;
  endfunction

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic send_item(input logic [idq_pkg::OP_W-1:0] op,
                           input logic [idq_pkg::VAL_W-1:0] val,
                           input logic [idq_pkg::POS_W-1:0] pos);
    deque_result_t res;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    position_i  <= pos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    res = deque_apply(op, val, pos);
    pending_results.push_back(res);
    op_seen[op]++;
    status_seen[res.status]++;
    items_sent++;
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // One random request, biased toward growing or shrinking the deque.
  task automatic send_random_item(input bit grow);
    logic [idq_pkg::OP_W-1:0]  op;
    logic [idq_pkg::VAL_W-1:0] val;
    logic [idq_pkg::POS_W-1:0] pos;
    int r;
    r = $urandom_range(0, 99);
    if (grow) begin
      if (r < 25) op = idq_pkg::OP_PUSH_FRONT;
      else if (r < 50) op = idq_pkg::OP_PUSH_BACK;
      else if (r < 58) op = idq_pkg::OP_POP_FRONT;
      else if (r < 66) op = idq_pkg::OP_POP_BACK;
      else if (r < 80) op = idq_pkg::OP_READ;
      else if (r < 90) op = idq_pkg::OP_WRITE;
      else if (r < 98) op = idq_pkg::OP_REMOVE;
      else op = OP_UNUSED;
    end else begin
      if (r < 10) op = idq_pkg::OP_PUSH_FRONT;
      else if (r < 20) op = idq_pkg::OP_PUSH_BACK;
      else if (r < 40) op = idq_pkg::OP_POP_FRONT;
      else if (r < 60) op = idq_pkg::OP_POP_BACK;
      else if (r < 72) op = idq_pkg::OP_READ;
      else if (r < 82) op = idq_pkg::OP_WRITE;
      else if (r < 98) op = idq_pkg::OP_REMOVE;
      else op = OP_UNUSED;
    end
    // draw values that repeat often so removals find matches
    case ($urandom_range(0, 3))
      0: val = value_pool[$urandom_range(0, 3)];
      1: val = deque_words[$urandom_range(0, deque_fill - 1)];
      default: val = $urandom;
    endcase
    if ($urandom_range(0, 3) == 0) pos = idq_pkg::POS_W'($urandom_range(0, 15));
    else pos = idq_pkg::POS_W'($urandom_range(0, deque_fill - 1));
    send_item(op, val, pos);
  endtask

  task automatic test_directed();
    send_item(idq_pkg::OP_READ, 32'h0, 4'd0);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    send_item(idq_pkg::OP_POP_BACK, 32'hFFFF_FFFF, 4'd15);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd1);
    send_item(idq_pkg::OP_WRITE, 32'hDEAD_BEEF, 4'd15);
    send_item(idq_pkg::OP_WRITE, 32'hFFFF_FFFF, 4'd0);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd0);
    send_item(idq_pkg::OP_PUSH_FRONT, 32'h0, 4'd0);
    send_item(idq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF, 4'd0);
    send_item(idq_pkg::OP_PUSH_BACK, 32'h5A5A_5A5A, 4'd0);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd1);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd3);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd4);
    send_item(idq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 4'd0);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd1);
    send_item(idq_pkg::OP_REMOVE, 32'h0, 4'd0);
    send_item(idq_pkg::OP_REMOVE, 32'h5A5A_5A5A, 4'd0);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
    send_item(idq_pkg::OP_PUSH_FRONT, 32'h0000_0001, 4'd15);
    send_item(idq_pkg::OP_POP_BACK, 32'h0, 4'd0);
    send_item(idq_pkg::OP_PUSH_BACK, 32'hA5A5_A5A5, 4'd0);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd0);
    idle($urandom_range(1, 4));
  endtask

  task automatic test_full();
    while (deque_fill < DEPTH) send_item(idq_pkg::OP_PUSH_BACK, $urandom, 4'd0);
    send_item(idq_pkg::OP_PUSH_FRONT, 32'h1111_1111, 4'd0);
    send_item(idq_pkg::OP_PUSH_BACK, 32'h2222_2222, 4'd0);
    send_item(idq_pkg::OP_WRITE, 32'hC3C3_C3C3, 4'd15);
    send_item(idq_pkg::OP_READ, 32'h0, 4'd15);
    // longest removal walk: full deque, nothing matches
    send_item(idq_pkg::OP_REMOVE, 32'h1234_5678, 4'd0);
    send_item(idq_pkg::OP_REMOVE, deque_words[3], 4'd0);
    while (deque_fill > 1) send_item(idq_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    send_item(idq_pkg::OP_POP_FRONT, 32'h0, 4'd0);
    wait_drained();
  endtask

  // Receiver holds off while items keep coming until the input stalls.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (40) send_random_item(1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int sent;
    int burst;
    bit grow;
    bit no_gap;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst  = $urandom_range(1, 24);
      grow   = 1'($urandom_range(0, 1));
      no_gap = ($urandom_range(0, 3) == 0);
      repeat (burst) send_random_item(grow);
      sent += burst;
      if (!no_gap) idle($urandom_range(1, 6));
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  // Receiver stall pattern: random stall modes that change over time, plus long hold-offs.
  initial begin
    int mode;
    int phase;
    mode = 0;
    phase = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (phase % 64 == 0) mode = $urandom_range(0, 3);
        phase++;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 30);
          2: out_stall_i <= ($urandom_range(0, 99) < 70);
          default: out_stall_i <= (phase % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    deque_result_t head;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: read_data %h count %0d status %0d",
               read_data_o, count_o, status_o);
        errors++;
      end else begin
        head = pending_results.pop_front();
        if (read_data_o !== head.read_data) begin
          $error("read_data: expected %h, actual %h", head.read_data, read_data_o);
          errors++;
        end
        if (count_o !== head.count) begin
          $error("count: expected %0d, actual %0d", head.count, count_o);
          errors++;
        end
        if (status_o !== head.status) begin
          $error("status: expected %0d, actual %0d", head.status, status_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) deque_words[i] = '0;
    deque_fill = 1;
    for (int i = 0; i < 8; i++) op_seen[i] = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    value_pool[0] = 32'h0;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = $urandom;
    value_pool[3] = $urandom;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("Sent %0d items: push front %0d, push back %0d, pop front %0d, pop back %0d,",
             items_sent, op_seen[idq_pkg::OP_PUSH_FRONT], op_seen[idq_pkg::OP_PUSH_BACK],
             op_seen[idq_pkg::OP_POP_FRONT], op_seen[idq_pkg::OP_POP_BACK]);
    $display("  read %0d, write %0d, remove %0d, unused code %0d; %0d results checked,",
             op_seen[idq_pkg::OP_READ], op_seen[idq_pkg::OP_WRITE],
             op_seen[idq_pkg::OP_REMOVE], op_seen[OP_UNUSED], results_checked);
    $display("  %0d refused pushes, %0d refused pops, %0d index errors",
             status_seen[idq_pkg::STAT_FULL], status_seen[idq_pkg::STAT_POP_REFUSED],
             status_seen[idq_pkg::STAT_RANGE]);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
